// ===== rtl/core/rc_channel_frame_parser_defines.svh =====
// Assertion helpers for the frame parser.
// Both sample on clk and are off while arst_n is low.
`ifndef RC_CHANNEL_FRAME_PARSER_DEFINES_SVH
`define RC_CHANNEL_FRAME_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rcfp_pkg.sv =====
package rcfp_pkg;

	localparam logic [7:0] HdrFirst  = 8'h20;
	localparam logic [7:0] HdrSecond = 8'h40;

	typedef logic [4:0] pos_t;
	localparam pos_t PosHunt      = 5'd0;
	localparam pos_t FirstDataPos = 5'd2;
	localparam pos_t LastPos      = 5'd21;

	localparam int NumCh   = 10;
	localparam int ChIdxW  = $clog2(NumCh);

	localparam logic [15:0] CentreReset = 16'd1500;
	localparam logic [15:0] ArmReset    = 16'd2000;

	// (mag*16384 + 250) / 500 == (mag*4096 + 62) / 125, exact for mag < 1024
	// via multiply by ceil(2^29 / 125) and a shift of 29.
	localparam int          MagBits     = 10;
	localparam int          NumW        = MagBits + 12;
	localparam logic [NumW-1:0] RoundBias = NumW'(62);
	localparam int          RecipW      = 23;
	localparam logic [RecipW-1:0] Recip125 = 23'd4294968;
	localparam int          RecipShift  = 29;
	localparam int          ProdW       = NumW + RecipW;

	localparam logic [15:0] PosLimit = 16'd32767;
	localparam logic [15:0] NegLimit = 16'd32768;

	typedef enum logic {
		REG_CENTRE = 1'b0,
		REG_ARM    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ===== rtl/core/rcfp_if.sv =====
interface rcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfp_rec_if;
	logic               valid;
	logic               ready;
	logic        [15:0] throttle;
	logic signed [15:0] roll_delta;
	logic signed [15:0] pitch_delta;
	logic signed [15:0] yaw_delta;
	logic        [15:0] knob_a;
	logic        [15:0] knob_b;
	logic        [15:0] switch_a;
	logic        [15:0] switch_b;
	logic        [15:0] switch_c;
	logic               armed;

	modport source (
		output valid, output throttle, output roll_delta, output pitch_delta,
		output yaw_delta, output knob_a, output knob_b, output switch_a,
		output switch_b, output switch_c, output armed, input ready
	);
	modport sink (
		input valid, input throttle, input roll_delta, input pitch_delta,
		input yaw_delta, input knob_a, input knob_b, input switch_a,
		input switch_b, input switch_c, input armed, output ready
	);
endinterface

// ===== rtl/core/rcfp_axis_scale.sv =====
module rcfp_axis_scale
	import rcfp_pkg::*;
(
	input  logic               clk,
	input  stage_en_t          en,
	input  logic signed [16:0] diff_s2,
	output logic signed [15:0] delta_s4
);

	logic              neg;
	logic [16:0]       mag;
	logic              big;
	logic [NumW-1:0]   num;
	logic [ProdW-1:0]  prod;

	logic              neg_s3;
	logic              big_s3;
	logic [15:0]       quo_s3;
	logic [15:0]       delta;

	always_comb begin
		neg  = diff_s2[16];
		mag  = neg ? 17'(-diff_s2) : 17'(diff_s2);
		// anything from 1024 up saturates either way
		big  = |mag[16:MagBits];
		num  = {mag[MagBits-1:0], 12'd0} + RoundBias;
		prod = ProdW'(num) * ProdW'(Recip125);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			neg_s3 <= neg;
			big_s3 <= big;
			quo_s3 <= prod[RecipShift +: 16];
		end
	end

	always_comb begin
		if (neg_s3) begin
			delta = (big_s3 || quo_s3 > NegLimit) ? NegLimit : 16'(-quo_s3);
		end else begin
			delta = (big_s3 || quo_s3 > PosLimit) ? PosLimit : quo_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			delta_s4 <= signed'(delta);
		end
	end

endmodule

// ===== rtl/core/rc_channel_frame_parser.sv =====
// Frame byte 21 enters s1; its record registers through s2, s3 and s4 and is presented from s4.
// Throughput: one byte a cycle unless stalled; framing registers update in the cycle a byte leaves s1.
// Pipeline: s1 byte register, s2 record/difference, s3 reciprocal multiply, s4 output.
// Reset (arst_n low): stage valids, frame position and previous byte clear, centre
// returns to 1500 and arm code to 2000; the channel byte store is not reset.
`include "rc_channel_frame_parser_defines.svh"

module rc_channel_frame_parser
	import rcfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	rcfp_byte_if.sink          rx,
	rcfp_rec_if.source         rec,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// ---------------------------------------------------------------
	// Config registers: centre at 0x0, arm code at 0x4
	// ---------------------------------------------------------------
	logic [15:0] centre_q;
	logic [15:0] arm_q;
	cfg_reg_t    reg_sel;
	logic        cfg_wr;

	assign reg_sel = cfg_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= CentreReset;
			arm_q    <= ArmReset;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_CENTRE: centre_q <= pwdata[15:0];
				REG_ARM:    arm_q    <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CENTRE: prdata = {16'd0, centre_q};
			REG_ARM:    prdata = {16'd0, arm_q};
			default:    prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// Stage handshakes: each stage loads when it is empty or the one
	// after it is loading, so a stalled record never blocks input
	// until every stage behind it is full.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	stage_en_t en;

	assign rdy_s4 = !v_s4 || rec.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign rx.ready = rdy_s1;
	assign en.s3 = rdy_s3;
	assign en.s4 = rdy_s4;

	// ---------------------------------------------------------------
	// s1: input byte register
	// ---------------------------------------------------------------
	logic [7:0] byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// Framing. Position 0 is hunting; 2..21 is the next frame byte.
	// The header check looks at the previous word whatever the state,
	// so the last frame byte can open the next header. Header values
	// inside a frame are plain data. Odd codes 1 and 22..31 hunt.
	// ---------------------------------------------------------------
	pos_t              pos_q;
	pos_t              pos_d;
	pos_t              pos_off;
	logic [7:0]        prev_q;
	logic              take_s1;
	logic              in_frame;
	logic              emit_s1;
	logic [ChIdxW-1:0] ch_idx;
	logic              hi_half;

	// low byte of every channel, high byte of all but the arm channel,
	// whose high byte is the word that completes the frame
	logic [7:0] lo_q [NumCh];
	logic [7:0] hi_q [NumCh-1];

	assign take_s1 = v_s1 && rdy_s2;

	always_comb begin
		in_frame = pos_q inside {[FirstDataPos:LastPos]};
		pos_off  = pos_q - FirstDataPos;
		ch_idx   = pos_off[ChIdxW:1];
		hi_half  = pos_off[0];
		emit_s1  = in_frame && (pos_q == LastPos);
		if (!in_frame) begin
			pos_d = (prev_q == HdrFirst && byte_s1 == HdrSecond) ? FirstDataPos : PosHunt;
		end else if (emit_s1) begin
			pos_d = PosHunt;
		end else begin
			pos_d = pos_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= PosHunt;
			prev_q <= 8'd0;
		end else if (take_s1) begin
			pos_q  <= pos_d;
			prev_q <= byte_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NumCh; i++) begin
			if (take_s1 && in_frame && !hi_half && ch_idx == ChIdxW'(i)) begin
				lo_q[i] <= byte_s1;
			end
		end
		for (int i = 0; i < NumCh - 1; i++) begin
			if (take_s1 && in_frame && hi_half && ch_idx == ChIdxW'(i)) begin
				hi_q[i] <= byte_s1;
			end
		end
	end

	// ---------------------------------------------------------------
	// s2: record register. Stick axes leave as centred differences.
	// ---------------------------------------------------------------
	logic        [15:0] throttle_s2, knob_a_s2, knob_b_s2;
	logic        [15:0] switch_a_s2, switch_b_s2, switch_c_s2;
	logic               armed_s2;
	logic signed [16:0] roll_s2, pitch_s2, yaw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= take_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			throttle_s2 <= {hi_q[2], lo_q[2]};
			knob_a_s2   <= {hi_q[4], lo_q[4]};
			knob_b_s2   <= {hi_q[5], lo_q[5]};
			switch_a_s2 <= {hi_q[6], lo_q[6]};
			switch_b_s2 <= {hi_q[7], lo_q[7]};
			switch_c_s2 <= {hi_q[8], lo_q[8]};
			armed_s2    <= ({byte_s1, lo_q[9]} == arm_q);
			roll_s2     <= signed'({1'b0, hi_q[0], lo_q[0]} - {1'b0, centre_q});
			pitch_s2    <= signed'({1'b0, hi_q[1], lo_q[1]} - {1'b0, centre_q});
			yaw_s2      <= signed'({1'b0, hi_q[3], lo_q[3]} - {1'b0, centre_q});
		end
	end

	// ---------------------------------------------------------------
	// s3/s4: axis scaling to Q1.14 with saturation, raw channels follow
	// ---------------------------------------------------------------
	rcfp_axis_scale u_roll  (.clk(clk), .en(en), .diff_s2(roll_s2),  .delta_s4(rec.roll_delta));
	rcfp_axis_scale u_pitch (.clk(clk), .en(en), .diff_s2(pitch_s2), .delta_s4(rec.pitch_delta));
	rcfp_axis_scale u_yaw   (.clk(clk), .en(en), .diff_s2(yaw_s2),   .delta_s4(rec.yaw_delta));

	logic [15:0] throttle_s3, knob_a_s3, knob_b_s3;
	logic [15:0] switch_a_s3, switch_b_s3, switch_c_s3;
	logic        armed_s3;
	logic [15:0] throttle_s4, knob_a_s4, knob_b_s4;
	logic [15:0] switch_a_s4, switch_b_s4, switch_c_s4;
	logic        armed_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			throttle_s3 <= throttle_s2;
			knob_a_s3   <= knob_a_s2;
			knob_b_s3   <= knob_b_s2;
			switch_a_s3 <= switch_a_s2;
			switch_b_s3 <= switch_b_s2;
			switch_c_s3 <= switch_c_s2;
			armed_s3    <= armed_s2;
		end
		if (rdy_s4) begin
			throttle_s4 <= throttle_s3;
			knob_a_s4   <= knob_a_s3;
			knob_b_s4   <= knob_b_s3;
			switch_a_s4 <= switch_a_s3;
			switch_b_s4 <= switch_b_s3;
			switch_c_s4 <= switch_c_s3;
			armed_s4    <= armed_s3;
		end
	end

	assign rec.valid    = v_s4;
	assign rec.throttle = throttle_s4;
	assign rec.knob_a   = knob_a_s4;
	assign rec.knob_b   = knob_b_s4;
	assign rec.switch_a = switch_a_s4;
	assign rec.switch_b = switch_b_s4;
	assign rec.switch_c = switch_c_s4;
	assign rec.armed    = armed_s4;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`RCFP_ASSERT_NEXT(a_emit_loads_s2, take_s1 && emit_s1, v_s2, "frame end lost before s2")
	`RCFP_ASSERT_NEXT(a_no_stray_rec, rdy_s2 && !(take_s1 && emit_s1), !v_s2, "stray record")
	`RCFP_ASSERT_NOW(a_pos_legal, 1'b1, (pos_q == PosHunt) || in_frame, "bad frame position")
	`RCFP_ASSERT_NOW(a_empty_takes, !rec.valid, rx.ready, "input stalled with output empty")

endmodule

// ===== dv/rc_channel_frame_parser_test.sv =====
`timescale 1ns / 1ps

module rc_channel_frame_parser_test;
	import rcfp_pkg::*;

	// cycles with no word moving on either channel before the run is abandoned
	localparam int QuietLimit = 3000;
	// receiver hold-off used to back the block up
	localparam int HoldCycles = 400;
	// frames of random content per phase
	localparam int FramesPerPhase = 13;

	typedef struct packed {
		logic [15:0] throttle;
		logic [15:0] roll_delta;
		logic [15:0] pitch_delta;
		logic [15:0] yaw_delta;
		logic [15:0] knob_a;
		logic [15:0] knob_b;
		logic [15:0] switch_a;
		logic [15:0] switch_b;
		logic [15:0] switch_c;
		logic        armed;
	} rc_record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	rcfp_byte_if rx_if ();
	rcfp_rec_if  rec_if ();

	rc_channel_frame_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.rec     (rec_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// words waiting for the driver, and records the parser is owed
	logic [7:0] rx_backlog [$];
	rc_record_t expected_records [$];

	// mirror of the parser: registers and framing state
	logic [15:0] centre;
	logic [15:0] arm;
	pos_t        frame_pos;
	logic [7:0]  prev_byte;
	logic [15:0] chan [NumCh];   // left unknown, as in the block

	logic [7:0] last_queued;     // last word put in the backlog
	int send_idle_pct;
	int recv_idle_pct;
	bit want_hold = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int errors = 0;

	// (raw - centre) * 16384 / 500, rounded half away from zero, then clamped
	function automatic logic [15:0] stick_q14(logic [15:0] raw);
		longint diff;
		longint mag;
		longint q;
		diff = longint'(raw) - longint'(centre);
		mag = (diff < 0) ? -diff : diff;
		q = (mag * 16384 + 250) / 500;
		if (diff < 0)
			return (q > 32768) ? 16'h8000 : 16'(-q);
		return (q > 32767) ? 16'h7FFF : 16'(q);
	endfunction

	// framing of one accepted word; queues a record when byte 21 lands
	function automatic void parse_byte(logic [7:0] b);
		int ch;
		rc_record_t r;
		if (frame_pos < FirstDataPos || frame_pos > LastPos) begin
			// hunting: the header may straddle the end of the last frame
			frame_pos = (prev_byte == HdrFirst && b == HdrSecond) ? FirstDataPos : PosHunt;
		end else begin
			ch = (frame_pos - FirstDataPos) >> 1;
			if (!frame_pos[0])
				chan[ch] = {8'h00, b};
			else
				chan[ch][15:8] = b;
			if (frame_pos == LastPos) begin
				// channel order on the wire: roll, pitch, throttle, yaw, knobs, switches, arm
				r.throttle    = chan[2];
				r.roll_delta  = stick_q14(chan[0]);
				r.pitch_delta = stick_q14(chan[1]);
				r.yaw_delta   = stick_q14(chan[3]);
				r.knob_a      = chan[4];
				r.knob_b      = chan[5];
				r.switch_a    = chan[6];
				r.switch_b    = chan[7];
				r.switch_c    = chan[8];
				r.armed       = (chan[9] == arm);
				expected_records.push_back(r);
				frame_pos = PosHunt;
			end else begin
				frame_pos = frame_pos + 5'd1;
			end
		end
		prev_byte = b;
	endfunction

	function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic void check_record();
		rc_record_t want;
		if (expected_records.size() == 0) begin
			$display("%0t: record expected none got throttle %h", $time, rec_if.throttle);
			errors++;
			return;
		end
		want = expected_records.pop_front();
		field_check("throttle", want.throttle, rec_if.throttle);
		field_check("roll_delta", want.roll_delta, rec_if.roll_delta);
		field_check("pitch_delta", want.pitch_delta, rec_if.pitch_delta);
		field_check("yaw_delta", want.yaw_delta, rec_if.yaw_delta);
		field_check("knob_a", want.knob_a, rec_if.knob_a);
		field_check("knob_b", want.knob_b, rec_if.knob_b);
		field_check("switch_a", want.switch_a, rec_if.switch_a);
		field_check("switch_b", want.switch_b, rec_if.switch_b);
		field_check("switch_c", want.switch_c, rec_if.switch_c);
		field_check("armed", 16'(want.armed), 16'(rec_if.armed));
	endfunction

	// ---- stimulus building ----

	function automatic void push_byte(logic [7:0] b);
		rx_backlog.push_back(b);
		last_queued = b;
	endfunction

	function automatic void queue_channels(logic [15:0] ch [NumCh]);
		for (int k = 0; k < NumCh; k++) begin
			push_byte(ch[k][7:0]);
			push_byte(ch[k][15:8]);
		end
	endfunction

	// mostly near centre so the scaling is exercised unclamped
	function automatic logic [15:0] stick_value();
		int pick;
		pick = $urandom_range(9);
		if (pick < 5)
			return centre + 16'($urandom_range(2200)) - 16'd1100;
		if (pick < 7) begin
			case ($urandom_range(5))
				0: return 16'h0000;
				1: return 16'hFFFF;
				2: return centre + 16'd999;
				3: return centre - 16'd999;
				4: return centre + 16'd1000;
				default: return centre - 16'd1000;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] arm_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return arm;
			4, 5: return arm ^ (16'd1 << $urandom_range(15));
			// high byte is the last frame word: lets it open the next header
			6: return {HdrFirst, 8'($urandom)};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void queue_frame(bit reuse_first);
		logic [15:0] ch [NumCh];
		if (!reuse_first)
			push_byte(HdrFirst);
		push_byte(HdrSecond);
		foreach (ch[k])
			ch[k] = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
				: 16'($urandom);
		ch[0] = stick_value();
		ch[1] = stick_value();
		ch[3] = stick_value();
		ch[9] = arm_value();
		queue_channels(ch);
	endfunction

	// line noise between frames; never forms a header by accident
	function automatic void queue_noise();
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1: begin
				repeat ($urandom_range(4, 1)) begin
					b = 8'($urandom);
					if (last_queued == HdrFirst && b == HdrSecond)
						b = ~HdrSecond;
					push_byte(b);
				end
			end
			2: begin
				// first header byte followed by something else
				push_byte(HdrFirst);
				b = 8'($urandom);
				if (b == HdrSecond)
					b = 8'h00;
				push_byte(b);
			end
			3: begin
				// second header byte on its own
				if (last_queued == HdrFirst)
					push_byte(8'h00);
				push_byte(HdrSecond);
			end
			4: repeat ($urandom_range(3, 1)) push_byte(HdrFirst);
			default: ;
		endcase
	endfunction

	// ---- config port ----

	task automatic set_register(cfg_reg_t idx, logic [15:0] value);
		logic [31:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_CENTRE: centre = value;
			REG_ARM:    arm = value;
			default:    ;
		endcase
		// straight into a read of the same register
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== {16'h0000, value}) begin
			$display("%0t: register %s expected %h got %h", $time, idx.name(),
				{16'h0000, value}, readback);
			errors++;
		end
	endtask

	// all words sent, all records back, then an idle wait for the pipe
	task automatic drain();
		do @(posedge clk);
		while (rx_backlog.size() != 0 || rx_if.valid || expected_records.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int f = 0; f < FramesPerPhase; f++) begin
			queue_noise();
			queue_frame(last_queued == HdrFirst && $urandom_range(1) == 1);
		end
		drain();
	endtask

	// ---- driver: offers backlog words, feeds the mirror on acceptance ----
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready)
				parse_byte(rx_if.rx_byte);
			if (!rx_if.valid || rx_if.ready) begin
				if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rx_if.valid <= 1'b1;
					rx_if.rx_byte <= rx_backlog.pop_front();
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor: checks records, drives ready, owns the long hold-off ----
	always @(posedge clk) begin
		if (arst_n) begin
			if (rec_if.valid && rec_if.ready)
				check_record();
			if (want_hold && !hold_done) begin
				hold_left = HoldCycles;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rec_if.ready <= 1'b0;
			end else begin
				rec_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ---- watchdog ----
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (rec_if.valid && rec_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no progress, %0d records outstanding", $time,
					expected_records.size());
				$display("rc_channel_frame_parser test failed");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] seed_frame [NumCh];
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		rec_if.ready = 1'b0;
		centre = CentreReset;
		arm = ArmReset;
		frame_pos = PosHunt;
		prev_byte = 8'h00;
		last_queued = 8'h00;
		send_idle_pct = 22;
		recv_idle_pct = 66;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: stray second header byte, then one frame holding header
		// words as data, both clamps, a one-step yaw and a last word of 0x20
		// that opens the next header
		seed_frame[0] = 16'h0000;
		seed_frame[1] = 16'hFFFF;
		seed_frame[2] = {HdrSecond, HdrFirst};
		seed_frame[3] = CentreReset + 16'd1;
		seed_frame[4] = 16'h0000;
		seed_frame[5] = 16'hFFFF;
		seed_frame[6] = {HdrFirst, HdrSecond};
		seed_frame[7] = 16'h5AA5;
		seed_frame[8] = 16'hA55A;
		seed_frame[9] = {HdrFirst, ArmReset[7:0]};
		push_byte(HdrSecond);
		push_byte(HdrFirst);
		push_byte(HdrSecond);
		queue_channels(seed_frame);
		queue_frame(1'b1);

		// reset register values; sender 22 %, receiver 66 % idle
		run_phase(22, 66);

		// low extremes; idling swapped
		set_register(REG_CENTRE, 16'h0000);
		set_register(REG_ARM, 16'h0000);
		run_phase(66, 22);

		// high extremes, no idling, receiver backs the block up
		set_register(REG_CENTRE, 16'hFFFF);
		set_register(REG_ARM, 16'hFFFF);
		want_hold = 1'b1;
		run_phase(0, 0);

		set_register(REG_CENTRE, 16'($urandom));
		set_register(REG_ARM, 16'($urandom));
		run_phase(22, 66);

		set_register(REG_CENTRE, CentreReset);
		set_register(REG_ARM, 16'($urandom));
		run_phase(66, 22);

		set_register(REG_CENTRE, 16'($urandom_range(2500, 500)));
		set_register(REG_ARM, ArmReset);
		run_phase(0, 0);

		if (errors == 0)
			$display("rc_channel_frame_parser test passed");
		else
			$display("rc_channel_frame_parser test failed");
		$finish;
	end

endmodule
